// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef struct packed {
      logic [31:0] msg_word;
      logic [5:0]  word_bits;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_type;

   typedef logic [7:0][31:0] vars_type;

   localparam logic [5:0]  FULL_BITS  = 6'd32;
   localparam logic [3:0]  LEN_SLOT   = 4'd14;
   localparam logic [31:0] MARK_WORD  = 32'h8000_0000;

   localparam vars_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [63:0][31:0] ROUND_K = {
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
   };

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] v);
      big_s0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] v);
      big_s1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] v);
      small_s0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] v);
      small_s1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

endpackage

// ===== rtl/sha_ram.sv =====
// ----------------------------------------------------------------------------
// sha_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/sha_round.sv =====
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round on the working variables a..h.
// ----------------------------------------------------------------------------
module sha_round
   import sha256_pkg::*;
(
   input  vars_type    vars,
   input  logic [31:0] k_word,
   input  logic [31:0] w_word,
   output vars_type    vars_next
);

   logic [31:0] t1, t2, ch, maj;

   always_comb begin
      ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
      maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
      t1  = vars[7] + big_s1(vars[4]) + ch + k_word + w_word;
      t2  = big_s0(vars[0]) + maj;
      vars_next[7] = vars[6];
      vars_next[6] = vars[5];
      vars_next[5] = vars[4];
      vars_next[4] = vars[3] + t1;
      vars_next[3] = vars[2];
      vars_next[2] = vars[1];
      vars_next[1] = vars[0];
      vars_next[0] = t1 + t2;
   end

endmodule

// ===== rtl/sha256_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 over a bit-granular message; block words and schedule kept in RAM.
// ----------------------------------------------------------------------------
//  channel  ports                        direction  handshake
//  request  start, busy, req_item        in         start && !busy
//  result   rsp_strobe, rsp_item         out        strobe, one cycle each
//
//  A word that does not fill a block is written to the block RAM. A full
//  block runs 64 rounds of the shared round unit, with the schedule in RAM.
//  A last word adds padding words, one or two more blocks and eight digest
//  words. Synchronous reset restores the initial hash.
//  The receiver cannot stall; busy holds off new words.
// ----------------------------------------------------------------------------
module sha256_message_digest
   import sha256_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   typedef enum logic [1:0] {S_IDLE, S_PAD, S_COMP, S_EMIT} state_type;

   state_type   state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [3:0]  slot_ff, slot_in;
   logic [63:0] count_ff, count_in;
   logic        pad_ff, pad_in, mark_ff, mark_in, hi_ff, hi_in, done_ff, done_in;
   vars_type    chain_ff, chain_in, vars_ff, vars_in, vars_next;
   logic [31:0] w_ff, w_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_item_ff, rsp_item_in;

   logic        accept, push, wr_en;
   logic [5:0]  bits;
   logic [31:0] masked, push_word, wr_data, w_calc;
   logic [3:0]  wr_addr, ra_a, ra_b, ra_c, ra_d;
   logic [31:0] rd_a, rd_b, rd_c, rd_d;
   logic [6:0]  t_sched;
   logic [5:0]  k_idx;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      bits = (req_item.last_word && req_item.word_bits <= FULL_BITS) ?
             req_item.word_bits : FULL_BITS;
      masked = req_item.msg_word & ~(32'hFFFF_FFFF >> bits);
   end

   // Schedule read addresses t-2, t-7, t-15, t
   always_comb begin
      ra_a = cnt_ff[3:0] - 4'd2;
      ra_b = cnt_ff[3:0] - 4'd7;
      ra_c = cnt_ff[3:0] - 4'd15;
      ra_d = cnt_ff[3:0];
      t_sched = cnt_ff - 7'd1;
      k_idx   = 6'(cnt_ff - 7'd2);
      w_calc  = (cnt_ff <= 7'd16) ? rd_d :
                small_s1(rd_a) + rd_b + small_s0(rd_c) + rd_d;
   end

   sha_ram #(.WIDTH(32), .DEPTH(16)) u_ram_lo (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr_a(ra_a), .rd_addr_b(ra_b), .rd_data_a(rd_a), .rd_data_b(rd_b)
   );

   sha_ram #(.WIDTH(32), .DEPTH(16)) u_ram_hi (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr_a(ra_c), .rd_addr_b(ra_d), .rd_data_a(rd_c), .rd_data_b(rd_d)
   );

   sha_round u_round (
      .vars(vars_ff), .k_word(ROUND_K[k_idx]), .w_word(w_ff), .vars_next(vars_next)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      hi_in    = hi_ff;
      done_in  = done_ff;
      chain_in = chain_ff;
      vars_in  = vars_ff;
      w_in     = w_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      push      = 1'b0;
      push_word = 32'd0;
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      wr_data   = 32'd0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               push     = 1'b1;
               count_in = count_ff + 64'(bits);
               if (req_item.last_word) begin
                  pad_in  = 1'b1;
                  mark_in = (bits == FULL_BITS);
                  hi_in   = 1'b0;
                  push_word = (bits == FULL_BITS) ? masked : (masked | (MARK_WORD >> bits));
               end else begin
                  push_word = masked;
               end
            end
         end
         S_PAD: begin
            push = 1'b1;
            if (mark_ff) begin
               push_word = MARK_WORD;
               mark_in   = 1'b0;
            end else if (hi_ff) begin
               push_word = count_ff[31:0];
               hi_in     = 1'b0;
               done_in   = 1'b1;
            end else if (slot_ff == LEN_SLOT) begin
               push_word = count_ff[63:32];
               hi_in     = 1'b1;
            end else begin
               push_word = 32'd0;
            end
         end
         S_COMP: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff >= 7'd1 && cnt_ff <= 7'd64) begin
               w_in    = w_calc;
               wr_en   = 1'b1;
               wr_addr = t_sched[3:0];
               wr_data = w_calc;
            end
            if (cnt_ff >= 7'd2 && cnt_ff <= 7'd65) begin
               vars_in = vars_next;
            end
            if (cnt_ff == 7'd66) begin
               for (int i = 0; i < 8; i++) begin
                  chain_in[i] = chain_ff[i] + vars_ff[i];
               end
               cnt_in = 7'd0;
               if (done_ff) begin
                  state_in = S_EMIT;
               end else if (pad_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            cnt_in = cnt_ff + 7'd1;
            rsp_strobe_in = 1'b1;
            rsp_item_in.digest_word = chain_ff[cnt_ff[2:0]];
            rsp_item_in.digest_last = (cnt_ff[2:0] == 3'd7);
            if (cnt_ff[2:0] == 3'd7) begin
               state_in = S_IDLE;
               chain_in = INIT_HASH;
               slot_in  = 4'd0;
               count_in = 64'd0;
               pad_in   = 1'b0;
               done_in  = 1'b0;
               cnt_in   = 7'd0;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (push) begin
         wr_en   = 1'b1;
         wr_addr = slot_ff;
         wr_data = push_word;
         slot_in = slot_ff + 4'd1;
         if (slot_ff == 4'd15) begin
            state_in = S_COMP;
            cnt_in   = 7'd0;
            vars_in  = chain_ff;
         end else begin
            state_in = pad_in ? S_PAD : S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= 7'd0;
         slot_ff       <= 4'd0;
         count_ff      <= 64'd0;
         pad_ff        <= 1'b0;
         mark_ff       <= 1'b0;
         hi_ff         <= 1'b0;
         done_ff       <= 1'b0;
         chain_ff      <= INIT_HASH;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         slot_ff       <= slot_in;
         count_ff      <= count_in;
         pad_ff        <= pad_in;
         mark_ff       <= mark_in;
         hi_ff         <= hi_in;
         done_ff       <= done_in;
         chain_ff      <= chain_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      vars_ff     <= vars_in;
      w_ff        <= w_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_last_word_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.last_word) |=> busy)
      else $error("last word did not start padding");

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_EMIT))
      else $error("digest word outside emit phase");

   a_slot_held_in_comp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMP && $past(state_ff == S_COMP)) |-> $stable(slot_ff))
      else $error("block slot moved during compression");

   a_last_needs_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_item.digest_last && rsp_strobe) |=> !rsp_strobe)
      else $error("digest word after final word");

endmodule

// ===== sim/tb_sha256_message_digest.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_message_digest
// Drives message words into the SHA-256 block, predicts each digest in a
// scoreboard and checks every digest word as it is strobed out.
// ----------------------------------------------------------------------------
module tb_sha256_message_digest;
   import sha256_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class digest_board;
      logic [31:0] hash_st[8];
      logic [31:0] blk[16];
      int unsigned slot;
      logic [63:0] nbits;
      rsp_type     pending[$];
      int unsigned errors;
      int unsigned digests;

      function new();
         errors = 0;
         digests = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) hash_st[i] = INIT_HASH[i];
         slot = 0;
         nbits = '0;
      endfunction

      function logic [31:0] ror(logic [31:0] v, int n);
         return (v >> n) | (v << (32 - n));
      endfunction

      function void compress();
         logic [31:0] v[8];
         logic [31:0] w, t1, t2;
         for (int i = 0; i < 8; i++) v[i] = hash_st[i];
         for (int r = 0; r < 64; r++) begin
            if (r < 16) w = blk[r];
            else begin
               w = (ror(blk[(r-2)&15],17) ^ ror(blk[(r-2)&15],19) ^ (blk[(r-2)&15] >> 10))
                 + blk[(r-7)&15]
                 + (ror(blk[(r-15)&15],7) ^ ror(blk[(r-15)&15],18) ^ (blk[(r-15)&15] >> 3))
                 + blk[r&15];
               blk[r&15] = w;
            end
            t1 = v[7] + (ror(v[4],6) ^ ror(v[4],11) ^ ror(v[4],25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w;
            t2 = (ror(v[0],2) ^ ror(v[0],13) ^ ror(v[0],22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) hash_st[i] += v[i];
      endfunction

      function void push(logic [31:0] w);
         blk[slot] = w;
         slot = (slot + 1) % 16;
         if (slot == 0) compress();
      endfunction

      function void note_word(req_type it);
         int n;
         logic [31:0] w;
         rsp_type r;
         n = it.word_bits;
         if (!it.last_word || n > 32) n = 32;
         w = (n == 0) ? 32'h0 : it.msg_word & (32'hffff_ffff << (32 - n));
         nbits += n;
         if (!it.last_word) begin
            push(w);
            return;
         end
         if (n < 32) push(w | (32'h1 << (31 - n)));
         else begin
            push(w);
            push(MARK_WORD);
         end
         while (slot != LEN_SLOT) push('0);
         push(nbits[63:32]);
         push(nbits[31:0]);
         for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_st[i];
            r.digest_last = (i == 7);
            pending = {pending, r};
         end
         digests++;
         restart();
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected digest word %h", got);
            return;
         end
         exp = pending.pop_front();
         if (got.digest_word !== exp.digest_word || got.digest_last !== exp.digest_last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp %h/%b got %h/%b", exp.digest_word, exp.digest_last,
                        got.digest_word, got.digest_last);
         end
      endfunction
   endclass

   logic    clock, reset, start, busy, rsp_strobe;
   req_type req_item;
   rsp_type rsp_item;
   int      sender_idle;
   int      quiet;
   int      words_sent;
   digest_board board;

   sha256_message_digest u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1;
      start = 0;
      req_item = '0;
      sender_idle = 0;
      words_sent = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_word(req_item);
            words_sent++;
         end
         if (rsp_strobe) board.check_word(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet = 0;
      else quiet++;
      if (quiet > 20000) begin
         $display("watchdog expired");
         $display("sha256_message_digest verification failed");
         $finish;
      end
   end

   task automatic send_word(logic [31:0] w, logic [5:0] nb, logic lst);
      if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
         start <= 0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle) @(posedge clock);
      end
      start <= 1;
      req_item <= '{msg_word: w, word_bits: nb, last_word: lst};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_message(int nwords, logic [5:0] tail_bits);
      for (int i = 0; i < nwords - 1; i++)
         send_word($urandom(), (($urandom_range(3) == 0) ? 6'($urandom_range(63)) : FULL_BITS),
                   1'b0);
      send_word($urandom(), tail_bits, 1'b1);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      quiet = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty, full, oversized, boundary lengths
      send_word(32'h0, 6'd0, 1'b1);
      send_word(32'hffff_ffff, 6'd32, 1'b1);
      send_word(32'hffff_ffff, 6'd63, 1'b1);
      send_word(32'hffff_ffff, 6'd1, 1'b1);
      send_word(32'haaaa_5555, 6'd31, 1'b1);
      send_word(32'h1234_5678, 6'd5, 1'b0);
      send_word(32'h5555_aaaa, 6'd40, 1'b1);
      send_message(14, 6'd31);
      send_message(14, 6'd32);
      send_message(16, 6'd0);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle = (ph == 0) ? 0 : (ph == 2) ? 38 : 62;
         while (words_sent < 55 + 23 * (ph + 1)) begin
            if ($urandom_range(9) == 0) send_word($urandom(), 6'($urandom_range(63)), 1'b1);
            else send_message($urandom_range(1, 20), 6'($urandom_range(63)));
         end
         drain();
      end
      repeat (100) @(posedge clock);
      $display("covered %0d words and %0d digests, empty to multi-block messages",
               words_sent, board.digests);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("sha256_message_digest verification clean");
      else
         $display("sha256_message_digest verification failed");
      $finish;
   end
endmodule
